[src/lidar_wall_centering_pd_macros.svh]
// Assertion macros for the top-level file that checks this block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LIDAR_WALL_CENTERING_PD_MACROS_SVH
`define LIDAR_WALL_CENTERING_PD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWC_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/lwc_pkg.sv]
package lwc_pkg;

	localparam int RANGE_W     = 16;
	localparam int ERR_W       = 17;
	localparam int GAIN_W      = 10;
	localparam int SPEED_W     = 10;
	localparam int SCAN_LEN_W  = 13;
	localparam int ANG_W       = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	localparam int PROD_P_W    = 28;
	localparam int DE_W        = 18;
	localparam int MAG_W       = 17;
	localparam int PROD1_W     = 27;
	localparam int DIVIDEND_W  = 37;
	localparam int SUM_W       = 39;
	localparam int SCALED_W    = SUM_W - 8;
	localparam int DIV_CNT_W   = 6;
	localparam int DERIV_SCALE = 1000;

	localparam logic [SCAN_LEN_W-1:0] RST_SCAN_LENGTH   = 13'd360;
	localparam logic [GAIN_W-1:0]     RST_GAIN_P        = 10'd51;
	localparam logic [GAIN_W-1:0]     RST_GAIN_D        = 10'd77;
	localparam logic [RANGE_W-1:0]    RST_END_THRESHOLD = 16'd100;
	localparam logic [SPEED_W-1:0]    RST_FORWARD_SPEED = 10'd300;
	localparam logic [RANGE_W-1:0]    RST_SCAN_INTERVAL = 16'd100;

	typedef enum logic [1:0] {
		FUNC_RANGE = 2'd0,
		FUNC_START = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SCAN_LENGTH   = 3'd0,
		CFG_GAIN_P        = 3'd1,
		CFG_GAIN_D        = 3'd2,
		CFG_END_THRESHOLD = 3'd3,
		CFG_FORWARD_SPEED = 3'd4
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SAMPLE,
		ST_SCAN_END,
		ST_THRESH,
		ST_PREP,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_SUM,
		ST_RESULT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic start;
		logic sample;
		logic scan_end;
		logic thresh;
		logic prep;
		logic mul1;
		logic mul2;
		logic div_step;
		logic sum;
		logic load_result;
		logic load_done;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       armed;
		logic       end_reached;
		logic       last_sample;
		logic       use_d;
		logic       div_last;
		logic       out_free;
	} status_t;

endpackage

[src/lwc_ctrl.sv]
module lwc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  lwc_pkg::status_t status,
	output lwc_pkg::cmd_t    cmd,
	output logic             in_stall
);
	import lwc_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (status.func)
					FUNC_START: state_next = ST_IDLE;
					FUNC_RANGE: state_next = status.armed ? ST_SAMPLE : ST_IDLE;
					FUNC_TICK: begin
						if (!status.armed) state_next = ST_IDLE;
						else if (status.end_reached) state_next = ST_DONE;
						else state_next = ST_PREP;
					end
					default: state_next = ST_IDLE;
				endcase
			end
			ST_SAMPLE:   state_next = status.last_sample ? ST_SCAN_END : ST_IDLE;
			ST_SCAN_END: state_next = ST_THRESH;
			ST_THRESH:   state_next = ST_IDLE;
			ST_PREP:     state_next = status.use_d ? ST_MUL1 : ST_SUM;
			ST_MUL1:     state_next = ST_MUL2;
			ST_MUL2:     state_next = ST_DIV;
			ST_DIV: begin
				if (status.div_last) state_next = ST_SUM;
			end
			ST_SUM:      state_next = ST_RESULT;
			ST_RESULT: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			ST_DONE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default:     state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_DECODE:   cmd.start    = (status.func == FUNC_START);
			ST_SAMPLE:   cmd.sample   = 1'b1;
			ST_SCAN_END: cmd.scan_end = 1'b1;
			ST_THRESH:   cmd.thresh   = 1'b1;
			ST_PREP:     cmd.prep     = 1'b1;
			ST_MUL1:     cmd.mul1     = 1'b1;
			ST_MUL2:     cmd.mul2     = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_SUM:      cmd.sum      = 1'b1;
			ST_RESULT:   cmd.load_result = status.out_free;
			ST_DONE:     cmd.load_done   = status.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[src/lwc_datapath.sv]
module lwc_datapath #(
	parameter int MAX_SCAN_SAMPLES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [lwc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lwc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [1:0]                          func,
	input  logic [lwc_pkg::RANGE_W-1:0]         range_mm,
	input  logic [lwc_pkg::RANGE_W-1:0]         interval_ms,
	input  logic                                out_stall,
	input  lwc_pkg::cmd_t                       cmd,
	output lwc_pkg::status_t                    status,
	output logic                                out_valid,
	output logic signed [lwc_pkg::ANG_W-1:0]    angular_mrad_s,
	output logic [lwc_pkg::SPEED_W-1:0]         linear_mm_s,
	output logic signed [lwc_pkg::ERR_W-1:0]    distance_error_mm,
	output logic                                corridor_done
);
	import lwc_pkg::*;

	localparam int CNT_W = $clog2(MAX_SCAN_SAMPLES);
	localparam int LEN_W = $clog2(MAX_SCAN_SAMPLES + 1);
	localparam int CMP_W = (LEN_W > SCAN_LEN_W) ? LEN_W : SCAN_LEN_W;

	// Configuration registers.
	logic [SCAN_LEN_W-1:0] scan_length_q;
	logic [GAIN_W-1:0]     gain_p_q;
	logic [GAIN_W-1:0]     gain_d_q;
	logic [RANGE_W-1:0]    end_threshold_q;
	logic [SPEED_W-1:0]    forward_speed_q;

	// Captured transaction.
	logic [1:0]            func_q;
	logic [RANGE_W-1:0]    range_q;
	logic [RANGE_W-1:0]    interval_q;

	// Scan and controller state.
	logic [RANGE_W-1:0]    left_min_q;
	logic [RANGE_W-1:0]    right_min_q;
	logic [CNT_W-1:0]      count_q;
	logic signed [ERR_W-1:0] wall_error_q;
	logic signed [ERR_W-1:0] prev_error_q;
	logic [RANGE_W-1:0]    scan_interval_q;
	logic                  first_tick_q;
	logic                  armed_q;
	logic                  end_reached_q;

	// Arithmetic working registers.
	logic signed [DE_W-1:0]     de_q;
	logic signed [PROD_P_W-1:0] p_q;
	logic                       use_d_q;
	logic                       d_neg_q;
	logic [PROD1_W-1:0]         prod1_q;
	logic [DIVIDEND_W-1:0]      quot_q;
	logic [RANGE_W-1:0]         rem_q;
	logic [DIV_CNT_W-1:0]       div_cnt_q;
	logic signed [SUM_W-1:0]    sum_q;

	// Output register.
	logic                    out_valid_q;
	logic signed [ANG_W-1:0] angular_q;
	logic [SPEED_W-1:0]      linear_q;
	logic signed [ERR_W-1:0] dist_err_q;
	logic                    done_q;

	logic [CMP_W-1:0]           scan_ext;
	logic [LEN_W-1:0]           len_eff;
	logic [LEN_W-1:0]           half_len;
	logic [LEN_W-1:0]           idx_ext;
	logic [LEN_W-1:0]           idx_next;
	logic                       last_sample;
	logic signed [DE_W-1:0]     de_full;
	logic signed [PROD_P_W-1:0] p_full;
	logic [MAG_W-1:0]           de_mag;
	logic [RANGE_W:0]           trial;
	logic                       trial_ge;
	logic signed [SUM_W-1:0]    d_val;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [ANG_W-1:0]    ang_sat;
	logic                       out_free;

	// Effective scan length is the register clamped to [2, MAX_SCAN_SAMPLES].
	always_comb begin
		scan_ext = CMP_W'(scan_length_q);
		if (scan_ext < CMP_W'(2)) begin
			len_eff = LEN_W'(2);
		end else if (scan_ext > CMP_W'(MAX_SCAN_SAMPLES)) begin
			len_eff = LEN_W'(MAX_SCAN_SAMPLES);
		end else begin
			len_eff = LEN_W'(scan_ext);
		end
		half_len    = len_eff >> 1;
		idx_ext     = LEN_W'(count_q);
		idx_next    = idx_ext + LEN_W'(1);
		last_sample = (idx_next >= len_eff);
	end

	always_comb begin
		de_full = $signed({wall_error_q[ERR_W-1], wall_error_q})
			- $signed({prev_error_q[ERR_W-1], prev_error_q});
		p_full  = $signed({1'b0, gain_p_q}) * wall_error_q;
		de_mag  = de_q[DE_W-1] ? MAG_W'(-de_q) : MAG_W'(de_q);
	end

	// One quotient bit per step of the restoring divider.
	always_comb begin
		trial    = {rem_q, quot_q[DIVIDEND_W-1]};
		trial_ge = (trial >= {1'b0, scan_interval_q});
	end

	always_comb begin
		d_val = '0;
		if (use_d_q) begin
			d_val = $signed({2'b00, quot_q});
			if (d_neg_q) d_val = -d_val;
		end
	end

	// Arithmetic shift gives the floor of the division by 256.
	always_comb begin
		scaled = SCALED_W'(sum_q >>> 8);
		if (!scaled[SCALED_W-1] && (|scaled[SCALED_W-2:ANG_W-1])) begin
			ang_sat = {1'b0, {(ANG_W-1){1'b1}}};
		end else if (scaled[SCALED_W-1] && !(&scaled[SCALED_W-2:ANG_W-1])) begin
			ang_sat = {1'b1, {(ANG_W-1){1'b0}}};
		end else begin
			ang_sat = scaled[ANG_W-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_length_q   <= RST_SCAN_LENGTH;
			gain_p_q        <= RST_GAIN_P;
			gain_d_q        <= RST_GAIN_D;
			end_threshold_q <= RST_END_THRESHOLD;
			forward_speed_q <= RST_FORWARD_SPEED;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_SCAN_LENGTH:   scan_length_q   <= cfg_data[SCAN_LEN_W-1:0];
				CFG_GAIN_P:        gain_p_q        <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:        gain_d_q        <= cfg_data[GAIN_W-1:0];
				CFG_END_THRESHOLD: end_threshold_q <= cfg_data[RANGE_W-1:0];
				CFG_FORWARD_SPEED: forward_speed_q <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			range_q    <= range_mm;
			interval_q <= interval_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_min_q      <= '1;
			right_min_q     <= '1;
			count_q         <= '0;
			wall_error_q    <= '0;
			prev_error_q    <= '0;
			scan_interval_q <= RST_SCAN_INTERVAL;
			first_tick_q    <= 1'b1;
			armed_q         <= 1'b0;
			end_reached_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				armed_q     <= 1'b1;
				count_q     <= '0;
				left_min_q  <= '1;
				right_min_q <= '1;
			end
			if (cmd.sample) begin
				if (idx_ext < half_len) begin
					if (range_q < left_min_q) left_min_q <= range_q;
				end else begin
					if (range_q < right_min_q) right_min_q <= range_q;
				end
				if (!last_sample) count_q <= CNT_W'(idx_next);
			end
			if (cmd.scan_end) begin
				wall_error_q    <= $signed({1'b0, left_min_q}) - $signed({1'b0, right_min_q});
				scan_interval_q <= interval_q;
				left_min_q      <= '1;
				right_min_q     <= '1;
				count_q         <= '0;
			end
			if (cmd.thresh) begin
				if (wall_error_q > $signed({1'b0, end_threshold_q})) end_reached_q <= 1'b1;
			end
			if (cmd.prep) begin
				prev_error_q <= wall_error_q;
				first_tick_q <= 1'b0;
			end
			if (cmd.load_done) begin
				armed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			de_q    <= de_full;
			p_q     <= p_full;
			use_d_q <= !first_tick_q && (scan_interval_q != '0);
		end
		if (cmd.mul1) begin
			d_neg_q <= de_q[DE_W-1];
			prod1_q <= gain_d_q * de_mag;
		end
		if (cmd.mul2) begin
			quot_q    <= prod1_q * DIVIDEND_W'(DERIV_SCALE);
			rem_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= trial_ge ? RANGE_W'(trial - {1'b0, scan_interval_q})
				: trial[RANGE_W-1:0];
			quot_q <= {quot_q[DIVIDEND_W-2:0], trial_ge};
		end
		if (cmd.sum) begin
			sum_q <= $signed({{(SUM_W-PROD_P_W){p_q[PROD_P_W-1]}}, p_q}) + d_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.mul2) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result || cmd.load_done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			angular_q  <= ang_sat;
			linear_q   <= forward_speed_q;
			dist_err_q <= wall_error_q;
			done_q     <= 1'b0;
		end else if (cmd.load_done) begin
			angular_q  <= '0;
			linear_q   <= '0;
			dist_err_q <= wall_error_q;
			done_q     <= 1'b1;
		end
	end

	always_comb begin
		status.func        = func_q;
		status.armed       = armed_q;
		status.end_reached = end_reached_q;
		status.last_sample = last_sample;
		status.use_d       = !first_tick_q && (scan_interval_q != '0);
		status.div_last    = (div_cnt_q == DIV_CNT_W'(DIVIDEND_W - 1));
		status.out_free    = out_free;
	end

	assign out_valid         = out_valid_q;
	assign angular_mrad_s    = angular_q;
	assign linear_mm_s       = linear_q;
	assign distance_error_mm = dist_err_q;
	assign corridor_done     = done_q;

endmodule

[src/lidar_wall_centering_pd.sv]
// Lidar wall-centering PD controller. A start transaction arms the block; range
// transactions of one scan then update the left (first half) and right (second half)
// minimum ranges, and the last sample of a scan forms the error left minus right and
// latches end of corridor when it exceeds end_threshold_mm. A control tick returns one
// result: a saturated PD turn rate with the fixed forward speed, or, once the end is
// latched, a done result with zero speeds that disarms the block. One transaction is
// in work at a time. A start passes decode; a range sample, decode and sample, and
// scan end and threshold after the last sample. A tick passes decode, prep, sum and
// result, with mul1, mul2 and a bit-serial divider (one quotient bit per cycle over 37
// bits) for a derivative term. A result waiting in the output register does not hold
// off the next transaction; only the load of a new result waits for it to be taken.
`include "lidar_wall_centering_pd_macros.svh"

module lidar_wall_centering_pd #(
	parameter int MAX_SCAN_SAMPLES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [lwc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lwc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic [lwc_pkg::RANGE_W-1:0]         range_mm,
	input  logic [lwc_pkg::RANGE_W-1:0]         interval_ms,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lwc_pkg::ANG_W-1:0]    angular_mrad_s,
	output logic [lwc_pkg::SPEED_W-1:0]         linear_mm_s,
	output logic signed [lwc_pkg::ERR_W-1:0]    distance_error_mm,
	output logic                                corridor_done
);
	import lwc_pkg::*;

	cmd_t    cmd;
	status_t status;

	lwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	lwc_datapath #(
		.MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.func              (func),
		.range_mm          (range_mm),
		.interval_ms       (interval_ms),
		.out_stall         (out_stall),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.angular_mrad_s    (angular_mrad_s),
		.linear_mm_s       (linear_mm_s),
		.distance_error_mm (distance_error_mm),
		.corridor_done     (corridor_done)
	);

	`LWC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted transaction did not make the block busy")
	`LWC_ASSERT_SAME(a_load_into_free_slot, cmd.load_result || cmd.load_done, !out_valid || !out_stall, "result loaded over a stalled result")
	`LWC_ASSERT_SAME(a_done_zero_speeds, out_valid && corridor_done, angular_mrad_s == '0 && linear_mm_s == '0, "done result carries a nonzero speed")
	`LWC_ASSERT_NEXT(a_done_disarms, cmd.load_done, !status.armed, "done result left the block armed")

endmodule
